// ===== rtl/npg_pkg.sv =====
// ----------------------------------------------------------------------------
// npg_pkg
// Shared widths, status codes and the request/response types of the
// iterative remainder unit of the next primes generator.
// ----------------------------------------------------------------------------
package npg_pkg;

	localparam int unsigned NPG_MAX_COUNT = 64;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned DIV_W    = VALUE_W / 2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LOW_START = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [DIV_W-1:0]   divisor;
	} npg_rem_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} npg_rem_rsp_t;

endpackage

// ===== rtl/npg_req_if.sv =====
// ----------------------------------------------------------------------------
// npg_req_if
// Request channel: start value and number of primes wanted.
// ----------------------------------------------------------------------------
interface npg_req_if import npg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] start_value;
	logic [COUNT_W-1:0] prime_count;

	modport source (output valid, output start_value, output prime_count, input ready);
	modport sink   (input valid, input start_value, input prime_count, output ready);
endinterface

// ===== rtl/npg_res_if.sv =====
// ----------------------------------------------------------------------------
// npg_res_if
// Result channel: one prime (or error word) per handshake.
// ----------------------------------------------------------------------------
interface npg_res_if import npg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  prime_value;
	logic                run_end;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output prime_value, output run_end, output status,
		input ready);
	modport sink   (input valid, input prime_value, input run_end, input status,
		output ready);
endinterface

// ===== rtl/npg_rem_unit.sv =====
// ----------------------------------------------------------------------------
// npg_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle, reports
// whether the divisor divides the dividend evenly.
// ----------------------------------------------------------------------------
module npg_rem_unit import npg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  npg_rem_req_t req,
	output npg_rem_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(VALUE_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] num_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   rem_q;
	logic               done_q;
	logic               zero_q;

	logic [DIV_W:0]     shifted;
	logic [DIV_W:0]     diff;
	logic [DIV_W-1:0]   rem_next;

	assign shifted  = {rem_q, num_q[VALUE_W-1]};
	assign diff     = shifted - {1'b0, div_q};
	assign rem_next = (shifted >= {1'b0, div_q}) ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			num_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= req.dividend;
				div_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_next;
				num_q <= {num_q[VALUE_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					zero_q <= (rem_next == '0);
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = zero_q;

endmodule

// ===== rtl/next_primes_generator_unit.sv =====
// ----------------------------------------------------------------------------
// next_primes_generator_unit
// Emits consecutive primes from a start value by trial division, using one
// shared bit-serial remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
// One request at a time. Per candidate: an even one goes from the check
// state straight to the next candidate; an odd one is tested against each
// odd trial divisor d (d*d <= candidate) in the remainder unit, from 3 up.
// Handshake: the request port is ready only while the sequencer is idle.
// Reset: arst_n clears the sequencer and the output valid; no store to clear.
// ----------------------------------------------------------------------------
module next_primes_generator_unit import npg_pkg::*; #(
	parameter int unsigned MAX_COUNT = NPG_MAX_COUNT
) (
	input  logic       clk,
	input  logic       arst_n,
	npg_req_if.sink    req,
	npg_res_if.source  res
);

	localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
	localparam int unsigned D_W   = DIV_W + 1;
	localparam int unsigned SQ_W  = VALUE_W + 2;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_TEST  = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_NEXT  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]          state_q;
	logic [VALUE_W-1:0]  cand_q;
	logic [D_W-1:0]      d_q;
	logic [SQ_W-1:0]     sq_q;
	logic [CNT_W-1:0]    left_q;

	logic [VALUE_W-1:0]  pend_value_q;
	logic                pend_end_q;
	logic [STATUS_W-1:0] pend_status_q;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic                out_end_q;
	logic [STATUS_W-1:0] out_status_q;

	npg_rem_req_t        rem_req;
	npg_rem_rsp_t        rem_rsp;

	logic                accept;
	logic                out_free;
	logic                sq_over;
	logic [CNT_W-1:0]    count_sat;

	assign accept   = req.valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || res.ready;
	assign sq_over  = sq_q > {2'b00, cand_q};

	assign count_sat = (req.prime_count > COUNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
		: CNT_W'(req.prime_count);

	assign rem_req.start    = (state_q == S_TEST) && !sq_over;
	assign rem_req.dividend = cand_q;
	assign rem_req.divisor  = d_q[DIV_W-1:0];

	npg_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cand_q        <= '0;
			d_q           <= '0;
			sq_q          <= '0;
			left_q        <= '0;
			pend_value_q  <= '0;
			pend_end_q    <= 1'b0;
			pend_status_q <= ST_OK;
			out_valid_q   <= 1'b0;
			out_value_q   <= '0;
			out_end_q     <= 1'b0;
			out_status_q  <= ST_OK;
		end else begin
			// the emit state refills the output word itself
			if (out_valid_q && res.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cand_q <= req.start_value;
						left_q <= count_sat;
						if (req.start_value < VALUE_W'(2)) begin
							pend_value_q  <= '0;
							pend_end_q    <= 1'b1;
							pend_status_q <= ST_LOW_START;
							state_q       <= S_EMIT;
						end else if (count_sat != '0) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (cand_q == VALUE_W'(2) || cand_q == VALUE_W'(3)) begin
						pend_value_q  <= cand_q;
						pend_end_q    <= (left_q == CNT_W'(1));
						pend_status_q <= ST_OK;
						state_q       <= S_EMIT;
					end else if (!cand_q[0]) begin
						state_q <= S_NEXT;
					end else begin
						d_q     <= D_W'(3);
						sq_q    <= SQ_W'(9);
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					if (sq_over) begin
						pend_value_q  <= cand_q;
						pend_end_q    <= (left_q == CNT_W'(1));
						pend_status_q <= ST_OK;
						state_q       <= S_EMIT;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (rem_rsp.done) begin
						if (rem_rsp.zero) begin
							state_q <= S_NEXT;
						end else begin
							// (d+2)^2 = d^2 + 4d + 4
							sq_q    <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
							d_q     <= d_q + D_W'(2);
							state_q <= S_TEST;
						end
					end
				end
				S_NEXT: begin
					if (cand_q == '1) begin
						pend_value_q  <= '0;
						pend_end_q    <= 1'b1;
						pend_status_q <= ST_NOT_FOUND;
						state_q       <= S_EMIT;
					end else begin
						cand_q  <= cand_q + 1'b1;
						state_q <= S_CHECK;
					end
				end
				S_EMIT: begin
					// hold until the output word is free
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= pend_value_q;
						out_end_q    <= pend_end_q;
						out_status_q <= pend_status_q;
						if (pend_end_q) begin
							state_q <= S_IDLE;
						end else begin
							left_q  <= left_q - 1'b1;
							state_q <= S_NEXT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign res.valid       = out_valid_q;
	assign res.prime_value = out_value_q;
	assign res.run_end     = out_end_q;
	assign res.status      = out_status_q;

endmodule
